/* hdl/wtw_pkg.sv */
// Shared types and constants for the weekly time window table.
// Holds the word formats, table entry layout, codes and control structs.
// No dependencies.
package wtw_pkg;

    localparam int DefMaxWindows = 16;
    localparam int MinPerHour    = 60;
    localparam int MinW          = 11;
    localparam int DayW          = 3;
    localparam int CntW          = 5;

    // opcodes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    // result status codes
    localparam logic [1:0] ST_STORED  = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BEG_END = 2'd3;

    // day groups beyond the single days
    localparam logic [3:0] GRP_LAST_SINGLE = 4'd6;
    localparam logic [3:0] GRP_WORKDAYS    = 4'd7;
    localparam logic [3:0] GRP_WEEKEND     = 4'd8;

    // days, Monday first
    localparam logic [DayW-1:0] DAY_MON = 3'd0;
    localparam logic [DayW-1:0] DAY_FRI = 3'd4;
    localparam logic [DayW-1:0] DAY_SAT = 3'd5;
    localparam logic [DayW-1:0] DAY_SUN = 3'd6;

    // weekday codes on a check, Sunday first
    localparam logic [DayW-1:0] WD_SUN     = 3'd0;
    localparam logic [DayW-1:0] WD_INVALID = 3'd7;

    typedef struct packed {
        logic       opcode;
        logic [3:0] day_group;
        logic [4:0] begin_hour;
        logic [5:0] begin_minute;
        logic [4:0] stop_hour;
        logic [5:0] end_minute;
        logic [2:0] weekday;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
    } in_word_t;

    typedef struct packed {
        logic [1:0]      status;
        logic            in_window;
        logic [CntW-1:0] entry_count;
    } out_word_t;

    typedef struct packed {
        logic [MinW-1:0] end_min;
        logic [MinW-1:0] begin_min;
        logic [DayW-1:0] last_day;
        logic [DayW-1:0] first_day;
    } entry_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic last;
        logic out_free;
    } stat_t;

    function automatic logic [MinW-1:0] to_minutes(input logic [4:0] hour,
                                                   input logic [5:0] minute);
        to_minutes = MinW'(hour) * MinW'(MinPerHour) + MinW'(minute);
    endfunction

endpackage

/* hdl/wtw_ctrl.sv */
// Sequencer for the weekly time window table.
// Drives load, scan step and finish commands to wtw_dp; uses wtw_pkg.
module wtw_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output wtw_pkg::cmd_t  cmd,
    input  wtw_pkg::stat_t stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    cmd.load   = 1'b1;
                    ready_next = 1'b0;
                    state_next = stat.empty ? S_FIN : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // hold until the output register can take the word
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    ready_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign in_ready = ready_reg;

endmodule

/* hdl/wtw_dp.sv */
// Datapath for the weekly time window table: item registers, entry memory,
// serial compare, entry count and output register. Uses wtw_pkg.
module wtw_dp #(
    parameter int MAX_WINDOWS = wtw_pkg::DefMaxWindows
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  wtw_pkg::in_word_t   in_data,
    input  wtw_pkg::cmd_t       cmd,
    output wtw_pkg::stat_t      stat,
    output logic                out_valid,
    input  logic                out_ready,
    output wtw_pkg::out_word_t  out_data
);

    localparam int CW = $clog2(MAX_WINDOWS + 1);
    localparam int IW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;

    wtw_pkg::entry_t mem [MAX_WINDOWS];
    wtw_pkg::entry_t rd_data_reg;
    logic [IW-1:0]   rd_addr;

    logic                           opcode_reg;
    logic [wtw_pkg::DayW-1:0]       first_reg, last_reg, day_reg;
    logic                           day_ok_reg;
    logic [wtw_pkg::MinW-1:0]       beg_reg, end_reg, cur_reg;
    logic                           hit_reg;
    logic [IW-1:0]                  idx_reg;
    logic [CW-1:0]                  count_reg, count_next;
    logic                           out_valid_reg;
    wtw_pkg::out_word_t             out_reg;

    logic [wtw_pkg::DayW-1:0] grp_first, grp_last, chk_day;
    logic                     chk_day_ok;
    logic                     in_time, add_match, chk_match, match;
    logic                     full, store;
    logic [1:0]               status_val;

    // day group to day range
    always_comb
    begin
        if (in_data.day_group <= wtw_pkg::GRP_LAST_SINGLE)
        begin
            grp_first = in_data.day_group[wtw_pkg::DayW-1:0];
            grp_last  = in_data.day_group[wtw_pkg::DayW-1:0];
        end
        else
        begin
            case (in_data.day_group)
                wtw_pkg::GRP_WORKDAYS:
                begin
                    grp_first = wtw_pkg::DAY_MON;
                    grp_last  = wtw_pkg::DAY_FRI;
                end
                wtw_pkg::GRP_WEEKEND:
                begin
                    grp_first = wtw_pkg::DAY_SAT;
                    grp_last  = wtw_pkg::DAY_SUN;
                end
                default:
                begin
                    grp_first = wtw_pkg::DAY_MON;
                    grp_last  = wtw_pkg::DAY_SUN;
                end
            endcase
        end
    end

    // Sunday-first weekday to Monday-first day
    always_comb
    begin
        chk_day_ok = (in_data.weekday != wtw_pkg::WD_INVALID);
        if (in_data.weekday == wtw_pkg::WD_SUN)
        begin
            chk_day = wtw_pkg::DAY_SUN;
        end
        else
        begin
            chk_day = in_data.weekday - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            opcode_reg <= in_data.opcode;
            first_reg  <= grp_first;
            last_reg   <= grp_last;
            day_reg    <= chk_day;
            day_ok_reg <= chk_day_ok;
            beg_reg    <= wtw_pkg::to_minutes(in_data.begin_hour, in_data.begin_minute);
            end_reg    <= wtw_pkg::to_minutes(in_data.stop_hour, in_data.end_minute);
            cur_reg    <= wtw_pkg::to_minutes(in_data.now_hour, in_data.now_minute);
        end
    end

    // entry compare for the word at the current scan position
    always_comb
    begin
        if (rd_data_reg.end_min > rd_data_reg.begin_min)
        begin
            in_time = (cur_reg >= rd_data_reg.begin_min) && (cur_reg <= rd_data_reg.end_min);
        end
        else
        begin
            // window wraps past midnight
            in_time = (cur_reg >= rd_data_reg.begin_min) || (cur_reg <= rd_data_reg.end_min);
        end
        add_match = (rd_data_reg.first_day <= first_reg) && (rd_data_reg.last_day >= last_reg)
                    && (rd_data_reg.begin_min == beg_reg) && (rd_data_reg.end_min == end_reg);
        chk_match = day_ok_reg && (day_reg >= rd_data_reg.first_day)
                    && (day_reg <= rd_data_reg.last_day) && in_time;
        match     = (opcode_reg == wtw_pkg::OP_CHECK) ? chk_match : add_match;
    end

    // next read: entry zero outside a scan step, the following entry during a scan
    assign rd_addr = cmd.step ? IW'(idx_reg + 1'b1) : '0;

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (store)
        begin
            mem[count_reg[IW-1:0]] <= '{end_min:   end_reg,
                                       begin_min: beg_reg,
                                       last_day:  last_reg,
                                       first_day: first_reg};
        end
    end

    always_comb
    begin
        full       = (count_reg == CW'(MAX_WINDOWS));
        store      = 1'b0;
        status_val = wtw_pkg::ST_STORED;
        if (opcode_reg == wtw_pkg::OP_ADD)
        begin
            if (beg_reg == end_reg)
            begin
                status_val = wtw_pkg::ST_BEG_END;
            end
            else if (hit_reg)
            begin
                status_val = wtw_pkg::ST_DUP;
            end
            else if (full)
            begin
                status_val = wtw_pkg::ST_FULL;
            end
            else
            begin
                store = cmd.finish;
            end
        end
        count_next = store ? count_reg + CW'(1) : count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.load)
            begin
                hit_reg <= 1'b0;
                idx_reg <= '0;
            end
            else if (cmd.step)
            begin
                hit_reg <= hit_reg | match;
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg.status      <= status_val;
            out_reg.in_window   <= (opcode_reg == wtw_pkg::OP_CHECK) && hit_reg;
            out_reg.entry_count <= wtw_pkg::CntW'(count_next);
        end
    end

    assign stat.empty    = (count_reg == '0);
    assign stat.last     = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* hdl/weekly_time_window_table.sv */
// Weekly time window table, top level: joins wtw_ctrl and wtw_dp.
// Uses wtw_pkg for word formats and control structs.
//
// Each input word is either an add of a window (day group plus begin and end
// time) or a check of a moment (weekday, hour, minute); every word gives one
// result word. After a word is accepted, the entries held are compared one
// per cycle through the single registered read port of the entry memory,
// and then the result is loaded into the output register. The input is
// ready again in the cycle after the result is loaded, even while it still
// waits to be taken, so a word is accepted only once the one before it is
// through; a result not yet taken holds the next one back in its final
// cycle. Reset empties the table by clearing the entry count alone; no
// clearing pass runs.
module weekly_time_window_table #(
    parameter int MAX_WINDOWS = wtw_pkg::DefMaxWindows
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  wtw_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output wtw_pkg::out_word_t out_data
);

    wtw_pkg::cmd_t  cmd;
    wtw_pkg::stat_t stat;

    wtw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    wtw_dp #(
        .MAX_WINDOWS (MAX_WINDOWS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.step, cmd.finish}))
        else $error("more than one datapath command at once");

    a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> stat.out_free)
        else $error("result loaded over a word not yet taken");

    a_step_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !stat.empty)
        else $error("scan step on an empty table");

    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !in_ready)
        else $error("ready while an item is in progress");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (MAX_WINDOWS > 31) || (out_data.entry_count <= MAX_WINDOWS))
        else $error("entry count beyond table size");

endmodule

/* sim/tb_weekly_time_window_table.sv */
// Testbench for weekly_time_window_table: directed vectors, then random add and check words,
// each result compared with its typed expected word or a local model of the window table.
// Depends on wtw_pkg and the weekly_time_window_table RTL.
module tb_weekly_time_window_table;

    localparam int         TableDepth  = wtw_pkg::DefMaxWindows;
    localparam int         RandomItems = 1800;
    localparam int         StallLimit  = 2000;
    localparam int         DrainCycles = 40;
    localparam int         HoldCycles  = 150;
    localparam int         IdlePct     = 18;
    localparam logic [1:0] StatusNone  = 2'd0;
    localparam logic [3:0] GrpAny      = 4'd9;

    typedef struct {
        wtw_pkg::in_word_t  word;
        bit                 typed;
        wtw_pkg::out_word_t want;
    } vector_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    wtw_pkg::in_word_t  in_data;
    logic               out_valid;
    logic               out_ready;
    wtw_pkg::out_word_t out_data;

    // local copy of the window table
    wtw_pkg::entry_t    tbl_entries [TableDepth];
    wtw_pkg::in_word_t  tbl_src     [TableDepth];
    int                 tbl_used;

    wtw_pkg::out_word_t pending_results [$];
    int                 items_sent;
    int                 results_seen;
    int                 errors;

    weekly_time_window_table #(
        .MAX_WINDOWS(TableDepth)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_error(input string what);
        errors++;
        $display("[%0t] mismatch on result %0d: %s", $time, results_seen, what);
    endtask

    function automatic wtw_pkg::in_word_t add_word(input logic [3:0] grp, input logic [4:0] bh,
                                                   input logic [5:0] bm, input logic [4:0] eh,
                                                   input logic [5:0] em);
        wtw_pkg::in_word_t w;
        w = '0;
        w.opcode       = wtw_pkg::OP_ADD;
        w.day_group    = grp;
        w.begin_hour   = bh;
        w.begin_minute = bm;
        w.stop_hour    = eh;
        w.end_minute   = em;
        return w;
    endfunction

    function automatic wtw_pkg::in_word_t check_word(input logic [2:0] wd, input logic [4:0] h,
                                                     input logic [5:0] m);
        wtw_pkg::in_word_t w;
        w = '0;
        w.opcode     = wtw_pkg::OP_CHECK;
        w.weekday    = wd;
        w.now_hour   = h;
        w.now_minute = m;
        return w;
    endfunction

    // Apply one word to the local table and return the result it gives.
    function automatic wtw_pkg::out_word_t window_table_step(input wtw_pkg::in_word_t w);
        wtw_pkg::out_word_t r;
        int                 b, e, now, day, lo, hi, eb, ee;
        r = '0;
        if (w.opcode == wtw_pkg::OP_ADD)
        begin
            b = int'(w.begin_hour) * wtw_pkg::MinPerHour + int'(w.begin_minute);
            e = int'(w.stop_hour) * wtw_pkg::MinPerHour + int'(w.end_minute);
            if (b == e)
                r.status = wtw_pkg::ST_BEG_END;
            else
            begin
                if (w.day_group <= wtw_pkg::GRP_LAST_SINGLE)
                begin
                    lo = int'(w.day_group);
                    hi = lo;
                end
                else if (w.day_group == wtw_pkg::GRP_WORKDAYS)
                begin
                    lo = int'(wtw_pkg::DAY_MON);
                    hi = int'(wtw_pkg::DAY_FRI);
                end
                else if (w.day_group == wtw_pkg::GRP_WEEKEND)
                begin
                    lo = int'(wtw_pkg::DAY_SAT);
                    hi = int'(wtw_pkg::DAY_SUN);
                end
                else
                begin
                    lo = int'(wtw_pkg::DAY_MON);
                    hi = int'(wtw_pkg::DAY_SUN);
                end
                r.status = wtw_pkg::ST_STORED;
                for (int i = 0; i < tbl_used; i++)
                    if (tbl_entries[i].first_day <= lo && tbl_entries[i].last_day >= hi &&
                        tbl_entries[i].begin_min == b && tbl_entries[i].end_min == e)
                        r.status = wtw_pkg::ST_DUP;
                // duplicate wins over full
                if (r.status == wtw_pkg::ST_STORED && tbl_used >= TableDepth)
                    r.status = wtw_pkg::ST_FULL;
                if (r.status == wtw_pkg::ST_STORED)
                begin
                    tbl_entries[tbl_used].first_day = wtw_pkg::DayW'(lo);
                    tbl_entries[tbl_used].last_day  = wtw_pkg::DayW'(hi);
                    tbl_entries[tbl_used].begin_min = wtw_pkg::MinW'(b);
                    tbl_entries[tbl_used].end_min   = wtw_pkg::MinW'(e);
                    tbl_src[tbl_used] = w;
                    tbl_used++;
                end
            end
        end
        else if (w.weekday != wtw_pkg::WD_INVALID)
        begin
            now = int'(w.now_hour) * wtw_pkg::MinPerHour + int'(w.now_minute);
            day = (w.weekday == wtw_pkg::WD_SUN) ? int'(wtw_pkg::DAY_SUN) : int'(w.weekday) - 1;
            for (int i = 0; i < tbl_used; i++)
            begin
                eb = int'(tbl_entries[i].begin_min);
                ee = int'(tbl_entries[i].end_min);
                // a window with end not after begin wraps past midnight
                if (day >= tbl_entries[i].first_day && day <= tbl_entries[i].last_day &&
                    ((ee > eb) ? (now >= eb && now <= ee) : (now >= eb || now <= ee)))
                    r.in_window = 1'b1;
            end
        end
        r.entry_count = wtw_pkg::CntW'(tbl_used);
        return r;
    endfunction

    function automatic wtw_pkg::in_word_t random_word();
        wtw_pkg::in_word_t w;
        int                k, lo, hi, day, add_pct;
        w = $bits(wtw_pkg::in_word_t)'({$urandom, $urandom});
        // raw noise: out-of-range times, unknown groups, weekday seven
        if ($urandom_range(99) < 10)
            return w;
        add_pct = (tbl_used < TableDepth) ? 45 : 20;
        if ($urandom_range(99) < add_pct)
        begin
            w.opcode       = wtw_pkg::OP_ADD;
            w.day_group    = 4'($urandom_range(9));
            w.begin_hour   = 5'($urandom_range(23));
            w.begin_minute = 6'($urandom_range(59));
            w.stop_hour    = 5'($urandom_range(23));
            w.end_minute   = 6'($urandom_range(59));
            k = int'($urandom_range(99));
            if (k < 12)
            begin
                w.stop_hour  = w.begin_hour;
                w.end_minute = w.begin_minute;
            end
            else if (k < 45 && tbl_used > 0)
            begin
                // repeat a held window over a subset of its days
                k = int'($urandom_range(tbl_used - 1));
                w.begin_hour   = tbl_src[k].begin_hour;
                w.begin_minute = tbl_src[k].begin_minute;
                w.stop_hour    = tbl_src[k].stop_hour;
                w.end_minute   = tbl_src[k].end_minute;
                lo = int'(tbl_entries[k].first_day);
                hi = int'(tbl_entries[k].last_day);
                if ($urandom_range(1) == 0)
                    w.day_group = 4'(lo + int'($urandom_range(hi - lo)));
                else if (lo == hi)
                    w.day_group = 4'(lo);
                else if (hi == wtw_pkg::DAY_FRI)
                    w.day_group = wtw_pkg::GRP_WORKDAYS;
                else if (lo == wtw_pkg::DAY_SAT)
                    w.day_group = wtw_pkg::GRP_WEEKEND;
                else
                    w.day_group = 4'(GrpAny + $urandom_range(6));
            end
        end
        else
        begin
            w.opcode     = wtw_pkg::OP_CHECK;
            w.weekday    = ($urandom_range(99) < 5) ? wtw_pkg::WD_INVALID
                                                    : 3'($urandom_range(6));
            w.now_hour   = 5'($urandom_range(23));
            w.now_minute = 6'($urandom_range(59));
            if ($urandom_range(99) < 60 && tbl_used > 0)
            begin
                // aim at a bound of a held window, on or just beside it
                k = int'($urandom_range(tbl_used - 1));
                if ($urandom_range(1) == 0)
                begin
                    w.now_hour   = tbl_src[k].begin_hour;
                    w.now_minute = tbl_src[k].begin_minute;
                end
                else
                begin
                    w.now_hour   = tbl_src[k].stop_hour;
                    w.now_minute = tbl_src[k].end_minute;
                end
                case ($urandom_range(2))
                    1: if (w.now_minute != 6'd63) w.now_minute++;
                    2: if (w.now_minute != 6'd0) w.now_minute--;
                    default: ;
                endcase
                if ($urandom_range(1) == 0)
                begin
                    day = int'(tbl_entries[k].first_day) +
                          int'($urandom_range(tbl_entries[k].last_day -
                                              tbl_entries[k].first_day));
                    w.weekday = (day == wtw_pkg::DAY_SUN) ? wtw_pkg::WD_SUN : 3'(day + 1);
                end
            end
        end
        return w;
    endfunction

    task automatic send_word(input wtw_pkg::in_word_t w, input bit typed,
                             input wtw_pkg::out_word_t want);
        wtw_pkg::out_word_t pred;
        bit                 calm;
        calm = (items_sent >= 900 && items_sent < 1200);
        while (!calm && $urandom_range(99) < IdlePct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pred = window_table_step(w);
        pending_results.push_back(typed ? want : pred);
        items_sent++;
    endtask

    // result side: random stalls, one long hold-off, field checks
    initial
    begin
        int                 hold_left;
        bit                 held;
        wtw_pkg::out_word_t want;
        hold_left = 0;
        held      = 1'b0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                    report_error($sformatf("unexpected word %h", out_data));
                else
                begin
                    want = pending_results.pop_front();
                    if (out_data.status !== want.status)
                        report_error($sformatf("status %0d, want %0d",
                                               out_data.status, want.status));
                    if (out_data.in_window !== want.in_window)
                        report_error($sformatf("in_window %0d, want %0d",
                                               out_data.in_window, want.in_window));
                    if (out_data.entry_count !== want.entry_count)
                        report_error($sformatf("entry_count %0d, want %0d",
                                               out_data.entry_count, want.entry_count));
                end
            end
            if (!held && results_seen == 300)
            begin
                hold_left = HoldCycles;
                held      = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (results_seen >= 900 && results_seen < 1200)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= IdlePct);
        end
    end

    initial
    begin
        int stalled;
        stalled = 0;
        while (stalled < StallLimit)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("watchdog: no word moved for %0d cycles", StallLimit);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        vector_t plan [$];
        tbl_used     = 0;
        items_sent   = 0;
        results_seen = 0;
        errors       = 0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;

        plan.push_back('{check_word(3'd1, 5'd12, 6'd0),
                         1'b1, '{StatusNone, 1'b0, 5'd0}});
        plan.push_back('{add_word(4'd0, 5'd0, 6'd0, 5'd0, 6'd0),
                         1'b1, '{wtw_pkg::ST_BEG_END, 1'b0, 5'd0}});
        plan.push_back('{add_word(GrpAny, 5'd9, 6'd0, 5'd17, 6'd0),
                         1'b1, '{wtw_pkg::ST_STORED, 1'b0, 5'd1}});
        plan.push_back('{add_word(wtw_pkg::GRP_WORKDAYS, 5'd9, 6'd0, 5'd17, 6'd0),
                         1'b1, '{wtw_pkg::ST_DUP, 1'b0, 5'd1}});
        plan.push_back('{add_word(wtw_pkg::GRP_WEEKEND, 5'd22, 6'd0, 5'd6, 6'd0),
                         1'b1, '{wtw_pkg::ST_STORED, 1'b0, 5'd2}});
        // unknown group acts as any day
        plan.push_back('{add_word(4'd15, 5'd23, 6'd59, 5'd0, 6'd0),    1'b0, '0});
        plan.push_back('{add_word(4'd6, 5'd31, 6'd63, 5'd0, 6'd0),     1'b0, '0});
        plan.push_back('{add_word(4'd3, 5'd0, 6'd0, 5'd31, 6'd63),     1'b0, '0});
        // 11:60 and 12:00 are the same minute
        plan.push_back('{add_word(4'd5, 5'd11, 6'd60, 5'd12, 6'd0),
                         1'b1, '{wtw_pkg::ST_BEG_END, 1'b0, 5'd5}});
        plan.push_back('{add_word(4'd2, 5'd10, 6'd30, 5'd10, 6'd31),   1'b0, '0});
        plan.push_back('{check_word(wtw_pkg::WD_INVALID, 5'd10, 6'd0),
                         1'b1, '{StatusNone, 1'b0, 5'd6}});
        plan.push_back('{check_word(wtw_pkg::WD_SUN, 5'd3, 6'd0),      1'b0, '0});
        plan.push_back('{check_word(3'd1, 5'd9, 6'd0),
                         1'b1, '{StatusNone, 1'b1, 5'd6}});
        plan.push_back('{check_word(3'd1, 5'd17, 6'd0),                1'b0, '0});
        plan.push_back('{check_word(3'd1, 5'd17, 6'd1),                1'b0, '0});
        plan.push_back('{check_word(3'd6, 5'd23, 6'd59),               1'b0, '0});
        plan.push_back('{check_word(wtw_pkg::WD_SUN, 5'd31, 6'd63),    1'b0, '0});
        plan.push_back('{check_word(3'd3, 5'd10, 6'd31),               1'b0, '0});
        plan.push_back('{add_word(4'd1, 5'd10, 6'd30, 5'd10, 6'd31),   1'b0, '0});
        plan.push_back('{check_word(3'd4, 5'd0, 6'd0),                 1'b0, '0});
        plan.push_back('{add_word(GrpAny, 5'd31, 6'd63, 5'd0, 6'd0),   1'b0, '0});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_word(plan[i].word, plan[i].typed, plan[i].want);
        for (int n = 0; n < RandomItems; n++)
            send_word(random_word(), 1'b0, '0);
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
hdl/wtw_pkg.sv
hdl/wtw_ctrl.sv
hdl/wtw_dp.sv
hdl/weekly_time_window_table.sv
sim/tb_weekly_time_window_table.sv
